// ===== rtl/core/i2cm_pkg.sv =====
// Types and constants shared by the I2C master byte engine.
package i2cm_pkg;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_ST_A    = 5'd1,
      PH_ST_B    = 5'd2,
      PH_ST_C    = 5'd3,
      PH_SP_A    = 5'd4,
      PH_SP_B    = 5'd5,
      PH_SP_C    = 5'd6,
      PH_WR_LO   = 5'd7,
      PH_WR_HI   = 5'd8,
      PH_WA_REL  = 5'd9,
      PH_WA_POLL = 5'd10,
      PH_WA_END  = 5'd11,
      PH_RD_LO   = 5'd12,
      PH_RD_HI   = 5'd13,
      PH_AK_LO   = 5'd14,
      PH_AK_HI   = 5'd15,
      PH_AK_END  = 5'd16
   } phase_type;

   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_START = 3'd1;
   localparam logic [2:0] ACT_STOP  = 3'd2;
   localparam logic [2:0] ACT_WRITE = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [3:0] BYTE_BITS         = 4'd8;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  bit_index;
      logic [7:0]  shift_reg;
      logic [7:0]  wait_count;
      logic        ack_choice;
      logic        error_flag;
      logic        scl;
      logic        rel;
      logic [7:0]  rx_hold;
   } eng_state_type;

   typedef struct packed {
      logic        scl_level;
      logic        sda_release;
      logic        busy_res;
      logic        done_res;
      logic [7:0]  rx_byte;
      logic        ack_error;
   } result_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  tx_byte;
      logic        send_ack;
      logic        sda_level;
   } request_type;

endpackage

// ===== rtl/core/i2c_master_byte_engine.sv =====
// I2C master byte engine: one request is one bus phase tick, one response per request.
// The engine takes one request per clock cycle when not stalled and answers each with one
// response: the request is captured in an input register, one bus phase is worked out
// from it and the sequencer state, and the line levels go to a response register. A stall
// on the response side holds both registers and stalls the request side in turn. The ack
// timeout register is written through the csr port, which is always ready.
module i2c_master_byte_engine (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_action,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_ack,
   input  logic       req_sda_level,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl_level,
   output logic       rsp_sda_release,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_ack_error,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import i2cm_pkg::*;

   logic          in_valid_ff, in_valid_in;
   request_type   in_req_ff;
   logic          out_valid_ff, out_valid_in;
   result_type    out_res_ff;
   eng_state_type state_ff;
   eng_state_type state_in;
   result_type    step_res;
   logic [7:0]    ack_timeout_ff;
   logic          req_take;
   logic          advance;

   i2cm_step u_step (
      .cur_state   (state_ff),
      .req         (in_req_ff),
      .ack_timeout (ack_timeout_ff),
      .nxt_state   (state_in),
      .res         (step_res)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else begin
         in_valid_in = in_valid_ff && !advance;
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else begin
         out_valid_in = out_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         ack_timeout_ff       <= ACK_TIMEOUT_RESET;
         state_ff.phase       <= PH_IDLE;
         state_ff.bit_index   <= 4'd0;
         state_ff.shift_reg   <= 8'd0;
         state_ff.wait_count  <= 8'd0;
         state_ff.ack_choice  <= 1'b0;
         state_ff.error_flag  <= 1'b0;
         state_ff.scl         <= 1'b1;
         state_ff.rel         <= 1'b1;
         state_ff.rx_hold     <= 8'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready) begin
            ack_timeout_ff <= csr_data;
         end
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_req_ff.action    <= req_action;
         in_req_ff.tx_byte   <= req_tx_byte;
         in_req_ff.send_ack  <= req_send_ack;
         in_req_ff.sda_level <= req_sda_level;
      end
      if (advance) begin
         out_res_ff <= step_res;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_scl_level   = out_res_ff.scl_level;
   assign rsp_sda_release = out_res_ff.sda_release;
   assign rsp_busy_res    = out_res_ff.busy_res;
   assign rsp_done_res    = out_res_ff.done_res;
   assign rsp_rx_byte     = out_res_ff.rx_byte;
   assign rsp_ack_error   = out_res_ff.ack_error;

endmodule

// ===== rtl/core/i2cm_step.sv =====
// Next-state and line-drive logic for one bus phase tick.
module i2cm_step (
   input  i2cm_pkg::eng_state_type cur_state,
   input  i2cm_pkg::request_type   req,
   input  logic [7:0]              ack_timeout,
   output i2cm_pkg::eng_state_type nxt_state,
   output i2cm_pkg::result_type    res
);
   import i2cm_pkg::*;

   eng_state_type st;
   logic          scl;
   logic          rel;
   logic          done;
   logic [3:0]    bit_inc;
   logic [7:0]    rd_shift;

   always_comb begin
      st       = cur_state;
      done     = 1'b0;
      if (st.phase == PH_IDLE) begin
         unique case (req.action)
            ACT_START: st.phase = PH_ST_A;
            ACT_STOP:  st.phase = PH_SP_A;
            ACT_WRITE: begin
               st.phase      = PH_WR_LO;
               st.shift_reg  = req.tx_byte;
               st.bit_index  = 4'd0;
               st.wait_count = 8'd0;
               st.error_flag = 1'b0;
            end
            ACT_READ: begin
               st.phase      = PH_RD_LO;
               st.shift_reg  = 8'd0;
               st.bit_index  = 4'd0;
               st.ack_choice = req.send_ack;
            end
            default: ;
         endcase
      end

      scl      = st.scl;
      rel      = st.rel;
      res.busy_res = (st.phase != PH_IDLE);
      bit_inc  = st.bit_index + 4'd1;
      rd_shift = {st.shift_reg[6:0], req.sda_level};

      unique case (st.phase)
         PH_IDLE: ;
         PH_ST_A: begin scl = 1'b1; rel = 1'b1; st.phase = PH_ST_B; end
         PH_ST_B: begin scl = 1'b1; rel = 1'b0; st.phase = PH_ST_C; end
         PH_ST_C: begin
            scl = 1'b0; rel = 1'b0; st.phase = PH_IDLE; done = 1'b1;
         end
         PH_SP_A: begin scl = 1'b0; rel = 1'b0; st.phase = PH_SP_B; end
         PH_SP_B: begin scl = 1'b1; rel = 1'b0; st.phase = PH_SP_C; end
         PH_SP_C: begin
            scl = 1'b1; rel = 1'b1; st.phase = PH_IDLE; done = 1'b1;
         end
         PH_WR_LO: begin
            scl = 1'b0; rel = st.shift_reg[7]; st.phase = PH_WR_HI;
         end
         PH_WR_HI: begin
            scl          = 1'b1;
            rel          = st.shift_reg[7];
            st.shift_reg = {st.shift_reg[6:0], 1'b0};
            st.bit_index = bit_inc;
            st.phase     = (bit_inc >= BYTE_BITS) ? PH_WA_REL : PH_WR_LO;
         end
         PH_WA_REL: begin scl = 1'b0; rel = 1'b1; st.phase = PH_WA_POLL; end
         PH_WA_POLL: begin
            scl = 1'b1;
            rel = 1'b1;
            if (!req.sda_level) begin
               st.phase = PH_WA_END;
            end else if (st.wait_count >= ack_timeout) begin
               st.error_flag = 1'b1;
               st.phase      = PH_SP_A;
            end else begin
               st.wait_count = st.wait_count + 8'd1;
            end
         end
         PH_WA_END: begin
            scl = 1'b0; rel = 1'b1; st.phase = PH_IDLE; done = 1'b1;
         end
         PH_RD_LO: begin scl = 1'b0; rel = 1'b1; st.phase = PH_RD_HI; end
         PH_RD_HI: begin
            scl          = 1'b1;
            rel          = 1'b1;
            st.shift_reg = rd_shift;
            st.bit_index = bit_inc;
            if (bit_inc >= BYTE_BITS) begin
               st.rx_hold = rd_shift;
               st.phase   = PH_AK_LO;
            end else begin
               st.phase = PH_RD_LO;
            end
         end
         PH_AK_LO: begin
            scl = 1'b0; rel = !st.ack_choice; st.phase = PH_AK_HI;
         end
         PH_AK_HI: begin
            scl = 1'b1; rel = !st.ack_choice; st.phase = PH_AK_END;
         end
         PH_AK_END: begin
            scl = 1'b0; rel = !st.ack_choice; st.phase = PH_IDLE; done = 1'b1;
         end
         default: st.phase = PH_IDLE;
      endcase

      st.scl          = scl;
      st.rel          = rel;
      nxt_state       = st;
      res.scl_level   = scl;
      res.sda_release = rel;
      res.done_res    = done;
      res.rx_byte     = st.rx_hold;
      res.ack_error   = st.error_flag;
   end

endmodule

// ===== rtl/core/i2cm_checker.sv =====
// Port-level checks for the I2C master byte engine and their binding.
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl_level,
   input logic       rsp_sda_release,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_ack_error
);

   // A completing phase always belongs to a command in progress.
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res)
      else $error("done without busy");

   // Only a stop ends with SCL high, and it ends with SDA released.
   a_stop_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && rsp_scl_level |-> rsp_sda_release)
      else $error("command ended with SCL high and SDA held low");

   // No response is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_scl_level)
         && $stable(rsp_sda_release) && $stable(rsp_rx_byte)
         && $stable(rsp_ack_error))
      else $error("stalled response changed");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);
